// ===== hdl/i2c_ras_pkg.sv =====
`timescale 1ns / 1ps

package i2c_ras_pkg;

   localparam int SLAVE_W = 7;
   localparam int BYTE_W  = 8;

   // request and status codes on the cmd field
   localparam logic [1:0] CMD_READ   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_BURST  = 2'd2;
   localparam logic [1:0] CMD_STATUS = 2'd3;

   localparam logic [SLAVE_W-1:0] AUTOINC_RESET = 7'd30;

   // engine status codes
   localparam logic [BYTE_W-1:0] ST_START   = 8'h08;
   localparam logic [BYTE_W-1:0] ST_RSTART  = 8'h10;
   localparam logic [BYTE_W-1:0] ST_SLAW    = 8'h18;
   localparam logic [BYTE_W-1:0] ST_DATA_TX = 8'h28;
   localparam logic [BYTE_W-1:0] ST_SLAR    = 8'h40;
   localparam logic [BYTE_W-1:0] ST_RX_ACK  = 8'h50;
   localparam logic [BYTE_W-1:0] ST_RX_NACK = 8'h58;

   localparam logic [BYTE_W-1:0] AUTOINC_BIT = 8'h80;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_START  = 3'd1,
      ACT_SEND   = 3'd2,
      ACT_RDACK  = 3'd3,
      ACT_RDNACK = 3'd4,
      ACT_STOP   = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_START  = 4'd1,
      PH_SLAW   = 4'd2,
      PH_SUB    = 4'd3,
      PH_DATA   = 4'd4,
      PH_RSTART = 4'd5,
      PH_SLAR   = 4'd6,
      PH_ACK    = 4'd7,
      PH_NACK   = 4'd8
   } phase_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [SLAVE_W-1:0] slave_addr;
      logic [BYTE_W-1:0]  reg_addr;
      logic [BYTE_W-1:0]  write_value;
      logic [BYTE_W-1:0]  count;
      logic [BYTE_W-1:0]  status;
      logic [BYTE_W-1:0]  rx_in;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [BYTE_W-1:0] tx_byte;
      logic              rx_valid;
      logic [BYTE_W-1:0] rx_byte;
      logic [BYTE_W-1:0] rx_index;
      logic              done_res;
      logic              success;
   } rsp_payload_type;

   function automatic logic [BYTE_W-1:0] expected_status(input phase_type ph);
      logic [BYTE_W-1:0] exp_code;
      unique case (ph)
         PH_START:          exp_code = ST_START;
         PH_SLAW:           exp_code = ST_SLAW;
         PH_SUB, PH_DATA:   exp_code = ST_DATA_TX;
         PH_RSTART:         exp_code = ST_RSTART;
         PH_SLAR:           exp_code = ST_SLAR;
         PH_ACK:            exp_code = ST_RX_ACK;
         PH_NACK:           exp_code = ST_RX_NACK;
         default:           exp_code = '0;
      endcase
      return exp_code;
   endfunction

endpackage

// ===== hdl/i2c_ras_if.sv =====
`timescale 1ns / 1ps

interface i2c_ras_req_if;
   import i2c_ras_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [SLAVE_W-1:0] slave_addr;
   logic [BYTE_W-1:0]  reg_addr;
   logic [BYTE_W-1:0]  write_value;
   logic [BYTE_W-1:0]  count;
   logic [BYTE_W-1:0]  status;
   logic [BYTE_W-1:0]  rx_in;

   modport source (
      output valid, cmd, slave_addr, reg_addr, write_value, count, status, rx_in,
      input  ready
   );
   modport sink (
      input  valid, cmd, slave_addr, reg_addr, write_value, count, status, rx_in,
      output ready
   );
endinterface

interface i2c_ras_rsp_if;
   import i2c_ras_pkg::*;

   logic              valid;
   logic              ready;
   logic [2:0]        action;
   logic [BYTE_W-1:0] tx_byte;
   logic              rx_valid;
   logic [BYTE_W-1:0] rx_byte;
   logic [BYTE_W-1:0] rx_index;
   logic              done_res;
   logic              success;

   modport source (
      output valid, action, tx_byte, rx_valid, rx_byte, rx_index, done_res, success,
      input  ready
   );
   modport sink (
      input  valid, action, tx_byte, rx_valid, rx_byte, rx_index, done_res, success,
      output ready
   );
endinterface

// ===== hdl/i2c_register_access_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake        Beat
// req_chan  in   valid / ready    request (cmd 0..2) or engine status (cmd 3)
// rsp_chan  out  valid / ready    one result beat per request beat
// csr_*     in   csr_wr_en        autoinc_slave, written on any edge with enable
//
// Beats pass input register, core, output register; one beat per cycle unless stalled.
// The loops are the phase and context registers feeding back into the decode stage.
// Reset is synchronous, active high; autoinc_slave returns to 30, phase to idle.
// A stalled result holds in the output register while the input register still fills.

module i2c_register_access_sequencer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [i2c_ras_pkg::SLAVE_W-1:0] csr_wr_data,
   i2c_ras_req_if.sink                     req_chan,
   i2c_ras_rsp_if.source                   rsp_chan
);
   import i2c_ras_pkg::*;

   req_payload_type req_data;
   req_payload_type held_req;
   rsp_payload_type core_rsp;
   rsp_payload_type out_rsp;
   logic            held_valid;
   logic            out_stage_ready;
   logic            fire;

   assign req_data.cmd         = req_chan.cmd;
   assign req_data.slave_addr  = req_chan.slave_addr;
   assign req_data.reg_addr    = req_chan.reg_addr;
   assign req_data.write_value = req_chan.write_value;
   assign req_data.count       = req_chan.count;
   assign req_data.status      = req_chan.status;
   assign req_data.rx_in       = req_chan.rx_in;

   i2c_ras_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_data),
      .out_valid (held_valid),
      .out_take  (fire),
      .out_data  (held_req)
   );

   i2c_ras_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (held_valid),
      .in_data     (held_req),
      .out_ready   (out_stage_ready),
      .fire        (fire),
      .out_data    (core_rsp)
   );

   i2c_ras_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_load   (fire),
      .in_ready  (out_stage_ready),
      .in_data   (core_rsp),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_rsp)
   );

   assign rsp_chan.action   = out_rsp.action;
   assign rsp_chan.tx_byte  = out_rsp.tx_byte;
   assign rsp_chan.rx_valid = out_rsp.rx_valid;
   assign rsp_chan.rx_byte  = out_rsp.rx_byte;
   assign rsp_chan.rx_index = out_rsp.rx_index;
   assign rsp_chan.done_res = out_rsp.done_res;
   assign rsp_chan.success  = out_rsp.success;

endmodule

// ===== hdl/i2c_ras_in_stage.sv =====
`timescale 1ns / 1ps

module i2c_ras_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  i2c_ras_pkg::req_payload_type in_data,
   output logic                         out_valid,
   input  logic                         out_take,
   output i2c_ras_pkg::req_payload_type out_data
);
   import i2c_ras_pkg::*;

   logic            valid_ff, valid_in;
   req_payload_type data_ff;

   // refill in the same cycle the held beat moves on
   assign in_ready = !valid_ff || out_take;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/i2c_ras_core.sv =====
`timescale 1ns / 1ps

module i2c_ras_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [i2c_ras_pkg::SLAVE_W-1:0]     csr_wr_data,
   input  logic                                in_valid,
   input  i2c_ras_pkg::req_payload_type        in_data,
   input  logic                                out_ready,
   output logic                                fire,
   output i2c_ras_pkg::rsp_payload_type        out_data
);
   import i2c_ras_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [1:0]         kind_ff, kind_in;
   logic [SLAVE_W-1:0] target_ff, target_in;
   logic [BYTE_W-1:0]  subaddr_ff, subaddr_in;
   logic [BYTE_W-1:0]  pending_ff, pending_in;
   logic [BYTE_W-1:0]  remaining_ff, remaining_in;
   logic [BYTE_W-1:0]  index_ff, index_in;
   logic [SLAVE_W-1:0] autoinc_ff;

   logic              is_req;
   logic              status_ok;
   logic [BYTE_W-1:0] rem_dec;
   logic              burst_autoinc;
   rsp_payload_type   rsp;

   assign fire          = in_valid && out_ready;
   assign is_req        = in_data.cmd != CMD_STATUS;
   assign status_ok     = in_data.status == expected_status(phase_ff);
   assign rem_dec       = remaining_ff - 1'b1;
   assign burst_autoinc = (kind_ff == CMD_BURST) && (target_ff == autoinc_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_req) begin
         if (phase_ff == PH_IDLE) begin
            phase_in = PH_START;
         end
      end else if (!status_ok) begin
         phase_in = PH_IDLE;
      end else begin
         unique case (phase_ff)
            PH_START:  phase_in = PH_SLAW;
            PH_SLAW:   phase_in = PH_SUB;
            PH_SUB:    phase_in = (kind_ff == CMD_WRITE) ? PH_DATA : PH_RSTART;
            PH_RSTART: phase_in = PH_SLAR;
            PH_SLAR: begin
               priority if (kind_ff != CMD_BURST || remaining_ff == 8'd1) begin
                  phase_in = PH_NACK;
               end else if (remaining_ff == '0) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_ACK;
               end
            end
            PH_ACK:    phase_in = (rem_dec <= 8'd1) ? PH_NACK : PH_ACK;
            default:   phase_in = PH_IDLE;
         endcase
      end
   end

   // result and transaction context
   always_comb begin
      rsp          = '0;
      kind_in      = kind_ff;
      target_in    = target_ff;
      subaddr_in   = subaddr_ff;
      pending_in   = pending_ff;
      remaining_in = remaining_ff;
      index_in     = index_ff;
      if (is_req) begin
         if (phase_ff == PH_IDLE) begin
            kind_in      = in_data.cmd;
            target_in    = in_data.slave_addr;
            subaddr_in   = in_data.reg_addr;
            pending_in   = in_data.write_value;
            remaining_in = in_data.count;
            index_in     = '0;
            rsp.action   = ACT_START;
         end
      end else if (phase_ff == PH_IDLE) begin
         rsp = '0;
      end else if (!status_ok) begin
         rsp.action   = ACT_STOP;
         rsp.done_res = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_START: begin
               rsp.action  = ACT_SEND;
               rsp.tx_byte = {target_ff, 1'b0};
            end
            PH_SLAW: begin
               rsp.action  = ACT_SEND;
               rsp.tx_byte = burst_autoinc ? (subaddr_ff | AUTOINC_BIT) : subaddr_ff;
            end
            PH_SUB: begin
               if (kind_ff == CMD_WRITE) begin
                  rsp.action  = ACT_SEND;
                  rsp.tx_byte = pending_ff;
               end else begin
                  rsp.action = ACT_START;
               end
            end
            PH_DATA: begin
               rsp.action   = ACT_STOP;
               rsp.done_res = 1'b1;
               rsp.success  = 1'b1;
            end
            PH_RSTART: begin
               rsp.action  = ACT_SEND;
               rsp.tx_byte = {target_ff, 1'b1};
            end
            PH_SLAR: begin
               priority if (kind_ff != CMD_BURST || remaining_ff == 8'd1) begin
                  rsp.action = ACT_RDNACK;
               end else if (remaining_ff == '0) begin
                  rsp.action   = ACT_STOP;
                  rsp.done_res = 1'b1;
                  rsp.success  = 1'b1;
               end else begin
                  rsp.action = ACT_RDACK;
               end
            end
            PH_ACK: begin
               rsp.rx_valid = 1'b1;
               rsp.rx_byte  = in_data.rx_in;
               rsp.rx_index = index_ff;
               index_in     = index_ff + 1'b1;
               remaining_in = rem_dec;
               rsp.action   = (rem_dec <= 8'd1) ? ACT_RDNACK : ACT_RDACK;
            end
            default: begin
               rsp.rx_valid = 1'b1;
               rsp.rx_byte  = in_data.rx_in;
               rsp.rx_index = index_ff;
               rsp.action   = ACT_STOP;
               rsp.done_res = 1'b1;
               rsp.success  = 1'b1;
            end
         endcase
      end
   end

   assign out_data = rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         kind_ff      <= '0;
         target_ff    <= '0;
         subaddr_ff   <= '0;
         pending_ff   <= '0;
         remaining_ff <= '0;
         index_ff     <= '0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         target_ff    <= target_in;
         subaddr_ff   <= subaddr_in;
         pending_ff   <= pending_in;
         remaining_ff <= remaining_in;
         index_ff     <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         autoinc_ff <= AUTOINC_RESET;
      end else if (csr_wr_en) begin
         autoinc_ff <= csr_wr_data;
      end
   end

`ifndef SYNTHESIS
   a_done_is_stop: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.done_res |-> rsp.action == ACT_STOP)
      else $error("done result without stop action");

   a_success_needs_done: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.success |-> rsp.done_res)
      else $error("success flagged without done");

   a_rx_only_in_read: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.rx_valid |-> (phase_ff == PH_ACK || phase_ff == PH_NACK))
      else $error("received byte delivered outside a read phase");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.done_res |=> phase_ff == PH_IDLE)
      else $error("transaction ended but sequencer not idle");
`endif

endmodule

// ===== hdl/i2c_ras_out_stage.sv =====
`timescale 1ns / 1ps

module i2c_ras_out_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_load,
   output logic                         in_ready,
   input  i2c_ras_pkg::rsp_payload_type in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output i2c_ras_pkg::rsp_payload_type out_data
);
   import i2c_ras_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
